### rtl/mps_pkg.sv
// Shared types, constants and small arithmetic helpers of the streaming max pool.
`default_nettype none
package mps_pkg;

  localparam int DATA_W    = 16;
  localparam int MAX_W     = 256;
  localparam int MAX_H     = 256;
  localparam int MAX_KERN  = 8;
  localparam int ACT_ROWS  = 32;
  localparam int ROW_AW    = $clog2(ACT_ROWS);
  localparam int COL_AW    = $clog2(MAX_W);
  localparam int RAM_AW    = ROW_AW + COL_AW;
  localparam int RAM_DEPTH = ACT_ROWS * MAX_W;
  localparam int LIST_N    = 16;

  localparam logic signed [DATA_W-1:0] MIN_VALUE = {1'b1, {(DATA_W-1){1'b0}}};

  // register indexes of the configuration port
  localparam logic [2:0] CFG_IN_HEIGHT   = 3'd0;
  localparam logic [2:0] CFG_IN_WIDTH    = 3'd1;
  localparam logic [2:0] CFG_KERN_HEIGHT = 3'd2;
  localparam logic [2:0] CFG_KERN_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_PAD         = 3'd4;
  localparam logic [2:0] CFG_STEP_SIZE   = 3'd5;
  localparam logic [2:0] CFG_TAP_SPACING = 3'd6;

  typedef logic signed [12:0] coord_t;

  // clamped geometry of one axis
  typedef struct packed {
    logic [8:0] n;
    logic [1:0] p;
    logic [3:0] s;
    logic [2:0] d;
    logic [4:0] kd;
  } axis_cfg_t;

  // one window seen by the axis scanner
  typedef struct packed {
    logic [7:0] idx;
    logic       tap;
    logic       first;
    logic       trig;
    logic       hit;
  } scan_ent_t;

  // round a value of at most three up to a multiple of the tap spacing
  function automatic logic [2:0] roundup_small(input logic [1:0] x, input logic [2:0] d);
    logic [2:0] r;
    case (d)
      3'd1:    r = {1'b0, x};
      3'd2:    r = {1'b0, x} + {2'b0, x[0]};
      3'd3:    r = (x != 2'd0) ? 3'd3 : 3'd0;
      default: r = (x != 2'd0) ? 3'd4 : 3'd0;
    endcase
    return r;
  endfunction

  // true when x is a multiple of the tap spacing
  function automatic logic mult_of(input logic [4:0] x, input logic [2:0] d);
    logic [11:0] prod;
    logic [4:0]  q;
    logic [6:0]  back;
    logic        r;
    prod = {7'b0, x} * 12'd43;
    q    = prod[11:7];
    back = {2'b0, q} * 7'd3;
    case (d)
      3'd1:    r = 1'b1;
      3'd2:    r = !x[0];
      3'd3:    r = (back == {2'b0, x});
      default: r = (x[1:0] == 2'b00);
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/mps_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module mps_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/mps_scan.sv
// Axis scanner: walks the windows around one position, one window per cycle.
`default_nettype none
module mps_scan (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                load,
  input  wire logic [8:0]          start_idx,
  input  wire mps_pkg::coord_t     start_base,
  input  wire logic [7:0]          pos,
  input  wire mps_pkg::axis_cfg_t  cfg,
  output mps_pkg::scan_ent_t       ent,
  output logic                     done
);

  logic [8:0]      idx;
  mps_pkg::coord_t base;
  mps_pkg::coord_t last, nm1, lim, posx, x, nb, ed, first, trig_hit, trig;
  logic [1:0]      neg, e;
  logic [2:0]      lo, hi_cut;
  logic            hit;

  // window bounds and trigger of the current window
  always_comb begin
    posx  = mps_pkg::coord_t'({5'b0, pos});
    last  = base + mps_pkg::coord_t'({8'b0, cfg.kd});
    nm1   = mps_pkg::coord_t'({4'b0, cfg.n}) - mps_pkg::coord_t'(1);
    lim   = nm1 + mps_pkg::coord_t'({11'b0, cfg.p});
    done  = idx[8] || (base > posx) || (last > lim);
    x     = posx - base;
    nb    = -base;
    neg   = (base < mps_pkg::coord_t'(0)) ? nb[1:0] : 2'b00;
    lo    = mps_pkg::roundup_small(neg, cfg.d);
    first = base + mps_pkg::coord_t'({10'b0, lo});
    ed    = last - nm1;
    e     = (last > nm1) ? ed[1:0] : 2'b00;
    hi_cut   = mps_pkg::roundup_small(e, cfg.d);
    trig_hit = last - mps_pkg::coord_t'({10'b0, hi_cut});
    hit   = (first <= trig_hit);
    if (hit) begin
      trig = trig_hit;
    end else if (last < mps_pkg::coord_t'(0)) begin
      trig = mps_pkg::coord_t'(0);
    end else begin
      trig = nm1;
    end
    ent.idx   = idx[7:0];
    ent.tap   = (x >= mps_pkg::coord_t'(0)) && (x <= mps_pkg::coord_t'({8'b0, cfg.kd}))
                && mps_pkg::mult_of(x[4:0], cfg.d);
    ent.first = (first == posx);
    ent.trig  = (trig == posx);
    ent.hit   = hit;
  end

  // load the first window, then advance one stride a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= 9'd0;
      base <= mps_pkg::coord_t'(0);
    end else if (load) begin
      idx  <= start_idx;
      base <= start_base;
    end else if (!done) begin
      idx  <= idx + 9'd1;
      base <= base + mps_pkg::coord_t'({9'b0, cfg.s});
    end
  end

endmodule
`default_nettype wire

### rtl/max_pool_2d_stream.sv
// Top level of the streaming 2D max pool with its pixel sequencer.
//
//  channel | direction | handshake           | payload
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//  in      | in        | in_valid/in_stall   | pixel_value
//  out     | out       | out_valid/out_stall | out_value, out_row, out_col, run_last
//
// A pixel passes through its steps in order: Nr and Nc windows scanned per axis
// (each at most 29), U open windows updated (at most 64), E results (at most 16),
// plus waits while a result is held on out_stall. The scanner steps one window a
// cycle and the partial-max memory does one read or one write a cycle.
// Reset (rst, synchronous) restores the register defaults and position (0,0); the
// memory is not cleared. A register write, taken only between pixels, restarts at (0,0).
`default_nettype none
module max_pool_2d_stream (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [8:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [15:0] pixel_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_value,
  output logic [7:0]              out_row,
  output logic [7:0]              out_col,
  output logic                    run_last
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_ROWS, ST_COLS, ST_UPD_RD, ST_UPD_WR, ST_EM_RD, ST_EM_WR, ST_ADV
  } state_t;

  state_t state;

  // configuration registers
  logic [8:0] in_height, in_width;
  logic [3:0] kern_height, kern_width, step_size;
  logic [1:0] pad;
  logic [2:0] tap_spacing;
  logic       cfg_we;

  // clamped geometry
  logic [8:0] h_eff, w_eff;
  logic [3:0] kh_eff, kw_eff, s_eff, kmin, phalf;
  logic [2:0] d_eff;
  logic [1:0] p_eff;
  logic [4:0] kdh, kdw;
  mps_pkg::axis_cfg_t row_cfg, col_cfg, scan_cfg;

  // position and first window of each axis
  logic [7:0]  cur_row, cur_col;
  logic [8:0]  row_sidx, col_sidx;
  logic [11:0] row_sraw, col_sraw;
  logic signed [15:0] pix;

  // window lists of the current pixel
  logic [7:0] rtap_idx [mps_pkg::LIST_N];
  logic       rtap_first [mps_pkg::LIST_N];
  logic [7:0] rtrg_idx [mps_pkg::LIST_N];
  logic       rtrg_hit [mps_pkg::LIST_N];
  logic [7:0] ctap_idx [mps_pkg::LIST_N];
  logic       ctap_first [mps_pkg::LIST_N];
  logic [7:0] ctrg_idx [mps_pkg::LIST_N];
  logic       ctrg_hit [mps_pkg::LIST_N];
  logic [4:0] rtap_n, rtrg_n, ctap_n, ctrg_n;
  logic [3:0] ii, jj;

  // scanner and memory
  logic                      scan_load, scan_done;
  logic [8:0]                scan_sidx;
  mps_pkg::coord_t           scan_sbase;
  logic [7:0]                scan_pos;
  mps_pkg::scan_ent_t        ent;
  logic                      ram_we, ram_re;
  logic [mps_pkg::RAM_AW-1:0] ram_addr;
  logic signed [15:0]        ram_wdata, ram_rdata;
  logic                      upd_phase, out_load, em_last, upd_last_j, upd_last_i;
  logic [8:0]                c1, r1;
  mps_pkg::coord_t           row_next_last, col_next_last;

  // take register writes only between pixels; hold the pixel while a write is offered
  assign cfg_ready = (state == ST_IDLE);
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_stall  = (state != ST_IDLE) || cfg_valid;

  // hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_height   <= 9'd64;
      in_width    <= 9'd64;
      kern_height <= 4'd2;
      kern_width  <= 4'd2;
      pad         <= 2'd0;
      step_size   <= 4'd2;
      tap_spacing <= 3'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mps_pkg::CFG_IN_HEIGHT:   in_height   <= cfg_data;
        mps_pkg::CFG_IN_WIDTH:    in_width    <= cfg_data;
        mps_pkg::CFG_KERN_HEIGHT: kern_height <= cfg_data[3:0];
        mps_pkg::CFG_KERN_WIDTH:  kern_width  <= cfg_data[3:0];
        mps_pkg::CFG_PAD:         pad         <= cfg_data[1:0];
        mps_pkg::CFG_STEP_SIZE:   step_size   <= cfg_data[3:0];
        mps_pkg::CFG_TAP_SPACING: tap_spacing <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // clamp the registers into the supported geometry
  always_comb begin
    h_eff  = (in_height == 9'd0) ? 9'd1 :
             ((in_height > 9'(mps_pkg::MAX_H)) ? 9'(mps_pkg::MAX_H) : in_height);
    w_eff  = (in_width == 9'd0) ? 9'd1 :
             ((in_width > 9'(mps_pkg::MAX_W)) ? 9'(mps_pkg::MAX_W) : in_width);
    kh_eff = (kern_height == 4'd0) ? 4'd1 :
             ((kern_height > 4'(mps_pkg::MAX_KERN)) ? 4'(mps_pkg::MAX_KERN) : kern_height);
    kw_eff = (kern_width == 4'd0) ? 4'd1 :
             ((kern_width > 4'(mps_pkg::MAX_KERN)) ? 4'(mps_pkg::MAX_KERN) : kern_width);
    s_eff  = (step_size == 4'd0) ? 4'd1 : ((step_size > 4'd8) ? 4'd8 : step_size);
    d_eff  = (tap_spacing == 3'd0) ? 3'd1 : ((tap_spacing > 3'd4) ? 3'd4 : tap_spacing);
    kmin   = (kh_eff < kw_eff) ? kh_eff : kw_eff;
    phalf  = kmin >> 1;
    p_eff  = ({2'b0, pad} > phalf) ? phalf[1:0] : pad;
    kdh    = 5'(({1'b0, kh_eff} - 5'd1) * {2'b0, d_eff});
    kdw    = 5'(({1'b0, kw_eff} - 5'd1) * {2'b0, d_eff});
    row_cfg = '{n: h_eff, p: p_eff, s: s_eff, d: d_eff, kd: kdh};
    col_cfg = '{n: w_eff, p: p_eff, s: s_eff, d: d_eff, kd: kdw};
  end

  // steer the shared scanner
  always_comb begin
    scan_cfg  = (state == ST_COLS) ? col_cfg : row_cfg;
    scan_pos  = (state == ST_COLS) ? cur_col : cur_row;
    scan_load = (state == ST_IDLE) || ((state == ST_ROWS) && scan_done);
    if (state == ST_ROWS) begin
      scan_sidx  = col_sidx;
      scan_sbase = mps_pkg::coord_t'({1'b0, col_sraw}) - mps_pkg::coord_t'({11'b0, p_eff});
    end else begin
      scan_sidx  = row_sidx;
      scan_sbase = mps_pkg::coord_t'({1'b0, row_sraw}) - mps_pkg::coord_t'({11'b0, p_eff});
    end
  end

  mps_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .load       (scan_load),
    .start_idx  (scan_sidx),
    .start_base (scan_sbase),
    .pos        (scan_pos),
    .cfg        (scan_cfg),
    .ent        (ent),
    .done       (scan_done)
  );

  // memory access for update and result reads
  always_comb begin
    upd_phase = (state == ST_UPD_RD) || (state == ST_UPD_WR);
    if (upd_phase) begin
      ram_addr = {rtap_idx[ii][mps_pkg::ROW_AW-1:0], ctap_idx[jj]};
    end else begin
      ram_addr = {rtrg_idx[ii][mps_pkg::ROW_AW-1:0], ctrg_idx[jj]};
    end
    ram_re    = (state == ST_UPD_RD) || (state == ST_EM_RD);
    ram_we    = (state == ST_UPD_WR);
    ram_wdata = ((rtap_first[ii] && ctap_first[jj]) || (pix > ram_rdata)) ? pix : ram_rdata;
    out_load  = (state == ST_EM_WR) && (!out_valid || !out_stall);
    em_last   = (({1'b0, ii} + 5'd1) == rtrg_n) && (({1'b0, jj} + 5'd1) == ctrg_n);
    upd_last_j = (({1'b0, jj} + 5'd1) == ctap_n);
    upd_last_i = (({1'b0, ii} + 5'd1) == rtap_n);
    c1 = {1'b0, cur_col} + 9'd1;
    r1 = {1'b0, cur_row} + 9'd1;
    row_next_last = mps_pkg::coord_t'({1'b0, row_sraw}) - mps_pkg::coord_t'({11'b0, p_eff})
                    + mps_pkg::coord_t'({8'b0, kdh});
    col_next_last = mps_pkg::coord_t'({1'b0, col_sraw}) - mps_pkg::coord_t'({11'b0, p_eff})
                    + mps_pkg::coord_t'({8'b0, kdw});
  end

  mps_ram #(
    .DEPTH (mps_pkg::RAM_DEPTH),
    .WIDTH (mps_pkg::DATA_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_addr),
    .rdata (ram_rdata)
  );

  // sequencer: scan, update, emit, advance
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_row   <= 8'd0;
      cur_col   <= 8'd0;
      row_sidx  <= 9'd0;
      row_sraw  <= 12'd0;
      col_sidx  <= 9'd0;
      col_sraw  <= 12'd0;
      rtap_n    <= 5'd0;
      rtrg_n    <= 5'd0;
      ctap_n    <= 5'd0;
      ctrg_n    <= 5'd0;
      ii        <= 4'd0;
      jj        <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cfg_we) begin
            if (cfg_index <= mps_pkg::CFG_TAP_SPACING) begin
              cur_row  <= 8'd0;
              cur_col  <= 8'd0;
              row_sidx <= 9'd0;
              row_sraw <= 12'd0;
              col_sidx <= 9'd0;
              col_sraw <= 12'd0;
            end
          end else if (in_valid) begin
            pix    <= pixel_value;
            rtap_n <= 5'd0;
            rtrg_n <= 5'd0;
            ctap_n <= 5'd0;
            ctrg_n <= 5'd0;
            state  <= ST_ROWS;
          end
        end
        ST_ROWS: begin
          if (scan_done) begin
            state <= ST_COLS;
          end else begin
            if (ent.tap && !rtap_n[4]) begin
              rtap_idx[rtap_n[3:0]]   <= ent.idx;
              rtap_first[rtap_n[3:0]] <= ent.first;
              rtap_n <= rtap_n + 5'd1;
            end
            if (ent.trig && !rtrg_n[4]) begin
              rtrg_idx[rtrg_n[3:0]] <= ent.idx;
              rtrg_hit[rtrg_n[3:0]] <= ent.hit;
              rtrg_n <= rtrg_n + 5'd1;
            end
          end
        end
        ST_COLS: begin
          if (scan_done) begin
            ii <= 4'd0;
            jj <= 4'd0;
            if (rtap_n != 5'd0 && ctap_n != 5'd0) begin
              state <= ST_UPD_RD;
            end else if (rtrg_n != 5'd0 && ctrg_n != 5'd0) begin
              state <= ST_EM_RD;
            end else begin
              state <= ST_ADV;
            end
          end else begin
            if (ent.tap && !ctap_n[4]) begin
              ctap_idx[ctap_n[3:0]]   <= ent.idx;
              ctap_first[ctap_n[3:0]] <= ent.first;
              ctap_n <= ctap_n + 5'd1;
            end
            if (ent.trig && !ctrg_n[4]) begin
              ctrg_idx[ctrg_n[3:0]] <= ent.idx;
              ctrg_hit[ctrg_n[3:0]] <= ent.hit;
              ctrg_n <= ctrg_n + 5'd1;
            end
          end
        end
        ST_UPD_RD: begin
          state <= ST_UPD_WR;
        end
        ST_UPD_WR: begin
          // write back, then step to the next open window
          if (!upd_last_j) begin
            jj    <= jj + 4'd1;
            state <= ST_UPD_RD;
          end else if (!upd_last_i) begin
            jj    <= 4'd0;
            ii    <= ii + 4'd1;
            state <= ST_UPD_RD;
          end else begin
            ii <= 4'd0;
            jj <= 4'd0;
            if (rtrg_n != 5'd0 && ctrg_n != 5'd0) begin
              state <= ST_EM_RD;
            end else begin
              state <= ST_ADV;
            end
          end
        end
        ST_EM_RD: begin
          state <= ST_EM_WR;
        end
        ST_EM_WR: begin
          if (out_load) begin
            out_value <= (rtrg_hit[ii] && ctrg_hit[jj]) ? ram_rdata : mps_pkg::MIN_VALUE;
            out_row   <= rtrg_idx[ii];
            out_col   <= ctrg_idx[jj];
            run_last  <= em_last;
            if (em_last) begin
              state <= ST_ADV;
            end else if (({1'b0, jj} + 5'd1) != ctrg_n) begin
              jj    <= jj + 4'd1;
              state <= ST_EM_RD;
            end else begin
              jj    <= 4'd0;
              ii    <= ii + 4'd1;
              state <= ST_EM_RD;
            end
          end
        end
        ST_ADV: begin
          // advance the position and the first open window of each axis
          state <= ST_IDLE;
          if (c1 == w_eff) begin
            cur_col  <= 8'd0;
            col_sidx <= 9'd0;
            col_sraw <= 12'd0;
            if (r1 == h_eff) begin
              cur_row  <= 8'd0;
              row_sidx <= 9'd0;
              row_sraw <= 12'd0;
            end else begin
              cur_row <= r1[7:0];
              if (row_next_last < mps_pkg::coord_t'({4'b0, r1})) begin
                row_sidx <= row_sidx + 9'd1;
                row_sraw <= row_sraw + {8'b0, s_eff};
              end
            end
          end else begin
            cur_col <= c1[7:0];
            if (col_next_last < mps_pkg::coord_t'({4'b0, c1})) begin
              col_sidx <= col_sidx + 9'd1;
              col_sraw <= col_sraw + {8'b0, s_eff};
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a register write restarts the frame
  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && (cfg_index <= mps_pkg::CFG_TAP_SPACING) && state == ST_IDLE)
    |=> (cur_row == 8'd0 && cur_col == 8'd0))
    else $error("frame position not cleared by register write");

  // the column position stays inside the frame
  a_col_in_frame: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, cur_col} < w_eff))
    else $error("column position outside the frame");

  // the last result of a pixel ends its processing
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_load && em_last) |=> (state == ST_ADV))
    else $error("pixel kept running after its last result");

  // memory writes only come after a read of the same pixel
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> $past(state == ST_UPD_RD))
    else $error("write back without a preceding read");

endmodule
`default_nettype wire
